@@ rtl/core/gnt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gnt_pkg
// Shared types, constants and helpers for the Gauss-Newton trilateration core.
// ----------------------------------------------------------------------------
package gnt_pkg;

    localparam int ANCHORS   = 3;
    localparam int FRAC_BITS = 16;
    // fraction bits of Jacobian, normal matrix and pivot multiplier
    localparam int JSH       = 29;

    localparam logic [63:0] LIMQ = 64'h4000_0000_0000_0000;
    // coordinates below about 1e-4 snap to zero
    localparam logic [63:0] SNAP_LIMIT =
        64'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

    typedef enum logic [1:0] {
        REG_START_X  = 2'd0,
        REG_START_Y  = 2'd1,
        REG_MAX_ITER = 2'd2,
        REG_STEP_TOL = 2'd3
    } gnt_reg_t;

    typedef enum logic [1:0] {
        STAT_CONV  = 2'd0,
        STAT_LIMIT = 2'd1,
        STAT_SING  = 2'd2
    } gnt_status_t;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } gnt_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ITER,
        ST_SQRT,
        ST_DIVX,
        ST_DIVY,
        ST_M00,
        ST_M01,
        ST_M11,
        ST_MG0,
        ST_MG1,
        ST_PIVOT,
        ST_DIVM,
        ST_U11,
        ST_G1,
        ST_D1,
        ST_T,
        ST_D0,
        ST_UPD,
        ST_DONE
    } gnt_state_t;

    typedef struct packed {
        logic signed [31:0] anchor_a_x;
        logic signed [31:0] anchor_a_y;
        logic        [30:0] anchor_a_range;
        logic signed [31:0] anchor_b_x;
        logic signed [31:0] anchor_b_y;
        logic        [30:0] anchor_b_range;
        logic signed [31:0] anchor_c_x;
        logic signed [31:0] anchor_c_y;
        logic        [30:0] anchor_c_range;
    } gnt_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [7:0]  iterations_used;
        logic        [1:0]  status;
    } gnt_out_t;

    typedef struct packed {
        logic               start;
        gnt_op_t            op;
        logic signed [63:0] opa;
        logic signed [63:0] opb;
    } gnt_alu_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] result;
    } gnt_alu_rsp_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(~v + 64'sd1) : 64'(v);
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/gauss_newton_trilateration.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gauss_newton_trilateration
// 2-D position fix from three circles by Gauss-Newton iteration.
//
// A request on the anchors channel carries three centres (Q16.16) and radii
// (unsigned Q15.16). It is taken when anchors_valid is high and anchors_stall
// low; the core then stalls anchors until the fix has gone to the output
// register. Each iteration runs three square roots, nine Q29 divisions and
// eighteen multiplies on one shared unit, whose divider is bit-serial. A solve
// runs at most max_iterations iterations, none for a limit of zero. The fix
// (position, iteration count, status) is held in an output register; while
// fix_stall is high it holds steady and the next request may already be
// taken and solved, the core waiting to deliver. Start point, iteration
// limit and step tolerance sit behind an APB port; the user must write them
// only while the core is idle, which the block does not enforce. Reset
// clears the control and sets start (-1.0, -1.0), limit 32, tolerance 1.
// ----------------------------------------------------------------------------
module gauss_newton_trilateration
    import gnt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        anchors_valid,
    output logic        anchors_stall,
    input  gnt_in_t     anchors,
    output logic        fix_valid,
    input  logic        fix_stall,
    output gnt_out_t    fix,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gnt_state_t         state_reg, state_next;
    logic signed [31:0] start_x_reg, start_y_reg;
    logic [7:0]         max_iter_reg;
    logic [15:0]        step_tol_reg;

    logic signed [31:0] ax_reg [ANCHORS], ax_next [ANCHORS];
    logic signed [31:0] ay_reg [ANCHORS], ay_next [ANCHORS];
    logic [30:0]        ar_reg [ANCHORS], ar_next [ANCHORS];
    logic signed [63:0] jx_reg [ANCHORS], jx_next [ANCHORS];
    logic signed [63:0] jy_reg [ANCHORS], jy_next [ANCHORS];
    logic signed [63:0] res_reg [ANCHORS], res_next [ANCHORS];

    logic signed [31:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [7:0]         iter_reg, iter_next;
    logic [1:0]         status_reg, status_next;
    logic [1:0]         i_reg, i_next;
    logic [32:0]        s_reg, s_next;
    logic signed [63:0] a00_reg, a00_next, a01_reg, a01_next;
    logic signed [63:0] a10_reg, a10_next, a11_reg, a11_next;
    logic signed [63:0] g0_reg, g0_next, g1_reg, g1_next;
    logic signed [63:0] d0_reg, d0_next, d1_reg, d1_next;
    logic               issued_reg, issued_next;
    gnt_out_t           out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    gnt_alu_req_t       alu_req;
    gnt_alu_rsp_t       alu_rsp;

    logic signed [63:0] dx, dy;
    logic [63:0]        dxm, dym;
    logic               big;
    logic [32:0]        s_new;
    logic               piv_sw;
    logic signed [63:0] piv_a00;
    logic               conv;
    logic               i_last;
    logic               out_free;
    logic               cfg_wr;
    logic               op_state;
    logic signed [63:0] r;

    function automatic logic signed [31:0] clamp_pos(input logic signed [63:0] v);
        logic signed [31:0] c;
        if (v > 64'sd2147483647)
            c = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            c = 32'sh8000_0000;
        else
            c = v[31:0];
        if (mag64(64'(c)) < SNAP_LIMIT)
            c = '0;
        return c;
    endfunction

    gnt_alu u_alu (
        .clk (clk),
        .rst_n (rst_n),
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        unique case (gnt_reg_t'(paddr[3:2]))
            REG_START_X:  prdata = start_x_reg;
            REG_START_Y:  prdata = start_y_reg;
            REG_MAX_ITER: prdata = {24'd0, max_iter_reg};
            REG_STEP_TOL: prdata = {16'd0, step_tol_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg  <= -32'sd65536;
            start_y_reg  <= -32'sd65536;
            max_iter_reg <= 8'd32;
            step_tol_reg <= 16'd1;
        end
        else if (cfg_wr)
        begin
            unique case (gnt_reg_t'(paddr[3:2]))
                REG_START_X:  start_x_reg  <= pwdata;
                REG_START_Y:  start_y_reg  <= pwdata;
                REG_MAX_ITER: max_iter_reg <= pwdata[7:0];
                REG_STEP_TOL: step_tol_reg <= pwdata[15:0];
                default:      start_x_reg  <= start_x_reg;
            endcase
        end
    end

    // shared helpers
    assign r      = alu_rsp.result;
    assign dx     = 64'(ex_reg) - 64'(ax_reg[i_reg]);
    assign dy     = 64'(ey_reg) - 64'(ay_reg[i_reg]);
    assign dxm    = mag64(dx);
    assign dym    = mag64(dy);
    assign big    = (dxm[63:31] != '0) || (dym[63:31] != '0);
    assign s_new  = big ? {r[31:0], 1'b0} : {1'b0, r[31:0]};
    assign piv_sw = mag64(a01_reg) > mag64(a00_reg);
    assign piv_a00 = piv_sw ? a01_reg : a00_reg;
    assign conv   = (mag64(d0_reg) <= 64'(step_tol_reg))
                 && (mag64(d1_reg) <= 64'(step_tol_reg));
    assign i_last = i_reg == 2'(ANCHORS - 1);
    assign out_free = !out_valid_reg || !fix_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (anchors_valid) state_next = ST_ITER;
            ST_ITER:  state_next = (iter_reg == max_iter_reg) ? ST_DONE : ST_SQRT;
            ST_SQRT:  if (alu_rsp.done) state_next = (s_new == '0) ? ST_DONE : ST_DIVX;
            ST_DIVX:  if (alu_rsp.done) state_next = ST_DIVY;
            ST_DIVY:  if (alu_rsp.done) state_next = i_last ? ST_M00 : ST_SQRT;
            ST_M00:   if (alu_rsp.done) state_next = ST_M01;
            ST_M01:   if (alu_rsp.done) state_next = ST_M11;
            ST_M11:   if (alu_rsp.done) state_next = ST_MG0;
            ST_MG0:   if (alu_rsp.done) state_next = ST_MG1;
            ST_MG1:   if (alu_rsp.done) state_next = i_last ? ST_PIVOT : ST_M00;
            ST_PIVOT: state_next = (piv_a00 == '0) ? ST_DONE : ST_DIVM;
            ST_DIVM:  if (alu_rsp.done) state_next = ST_U11;
            ST_U11:   if (alu_rsp.done) state_next = ST_G1;
            ST_G1:    if (alu_rsp.done) state_next = (a11_reg == '0) ? ST_DONE : ST_D1;
            ST_D1:    if (alu_rsp.done) state_next = ST_T;
            ST_T:     if (alu_rsp.done) state_next = ST_D0;
            ST_D0:    if (alu_rsp.done) state_next = ST_UPD;
            ST_UPD:   state_next = conv ? ST_DONE : ST_ITER;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs: handshake and shared unit requests
    always_comb
    begin
        op_state    = 1'b1;
        alu_req.op  = OP_MUL;
        alu_req.opa = '0;
        alu_req.opb = '0;
        unique case (state_reg)
            ST_SQRT:
            begin
                alu_req.op  = OP_SQRT;
                alu_req.opa = big ? 64'(dxm[32:1]) : 64'(dxm[31:0]);
                alu_req.opb = big ? 64'(dym[32:1]) : 64'(dym[31:0]);
            end
            ST_DIVX:
            begin
                alu_req.op  = OP_DIV;
                alu_req.opa = dx;
                alu_req.opb = 64'(s_reg);
            end
            ST_DIVY:
            begin
                alu_req.op  = OP_DIV;
                alu_req.opa = dy;
                alu_req.opb = 64'(s_reg);
            end
            ST_M00:
            begin
                alu_req.opa = jx_reg[i_reg];
                alu_req.opb = jx_reg[i_reg];
            end
            ST_M01:
            begin
                alu_req.opa = jx_reg[i_reg];
                alu_req.opb = jy_reg[i_reg];
            end
            ST_M11:
            begin
                alu_req.opa = jy_reg[i_reg];
                alu_req.opb = jy_reg[i_reg];
            end
            ST_MG0:
            begin
                alu_req.opa = jx_reg[i_reg];
                alu_req.opb = res_reg[i_reg];
            end
            ST_MG1:
            begin
                alu_req.opa = jy_reg[i_reg];
                alu_req.opb = res_reg[i_reg];
            end
            ST_DIVM:
            begin
                alu_req.op  = OP_DIV;
                alu_req.opa = a10_reg;
                alu_req.opb = a00_reg;
            end
            ST_U11:
            begin
                alu_req.opa = a01_reg;
                alu_req.opb = a10_reg;
            end
            ST_G1:
            begin
                alu_req.opa = g0_reg;
                alu_req.opb = a10_reg;
            end
            ST_D1:
            begin
                alu_req.op  = OP_DIV;
                alu_req.opa = g1_reg;
                alu_req.opb = a11_reg;
            end
            ST_T:
            begin
                alu_req.opa = a01_reg;
                alu_req.opb = d1_reg;
            end
            ST_D0:
            begin
                alu_req.op  = OP_DIV;
                alu_req.opa = g0_reg;
                alu_req.opb = a00_reg;
            end
            default: op_state = 1'b0;
        endcase
        alu_req.start = op_state && !issued_reg;
        anchors_stall = state_reg != ST_IDLE;
    end

    // datapath
    always_comb
    begin
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        ar_next     = ar_reg;
        jx_next     = jx_reg;
        jy_next     = jy_reg;
        res_next    = res_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        iter_next   = iter_reg;
        status_next = status_reg;
        i_next      = i_reg;
        s_next      = s_reg;
        a00_next    = a00_reg;
        a01_next    = a01_reg;
        a10_next    = a10_reg;
        a11_next    = a11_reg;
        g0_next     = g0_reg;
        g1_next     = g1_reg;
        d0_next     = d0_reg;
        d1_next     = d1_reg;
        out_next    = out_reg;
        out_valid_next = out_valid_reg && fix_stall;

        issued_next = issued_reg;
        if (alu_req.start)
            issued_next = 1'b1;
        if (alu_rsp.done)
            issued_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (anchors_valid)
                begin
                    ax_next[0] = anchors.anchor_a_x;
                    ay_next[0] = anchors.anchor_a_y;
                    ar_next[0] = anchors.anchor_a_range;
                    ax_next[1] = anchors.anchor_b_x;
                    ay_next[1] = anchors.anchor_b_y;
                    ar_next[1] = anchors.anchor_b_range;
                    ax_next[2] = anchors.anchor_c_x;
                    ay_next[2] = anchors.anchor_c_y;
                    ar_next[2] = anchors.anchor_c_range;
                    ex_next     = start_x_reg;
                    ey_next     = start_y_reg;
                    iter_next   = '0;
                    status_next = STAT_LIMIT;
                end
            end
            ST_ITER:
            begin
                if (iter_reg != max_iter_reg)
                begin
                    iter_next = iter_reg + 8'd1;
                    i_next    = '0;
                    a00_next  = '0;
                    a01_next  = '0;
                    a11_next  = '0;
                    g0_next   = '0;
                    g1_next   = '0;
                end
            end
            ST_SQRT:
            begin
                if (alu_rsp.done)
                begin
                    s_next = s_new;
                    if (s_new == '0)
                        status_next = STAT_SING;
                end
            end
            ST_DIVX: if (alu_rsp.done) jx_next[i_reg] = r;
            ST_DIVY:
            begin
                if (alu_rsp.done)
                begin
                    jy_next[i_reg]  = r;
                    res_next[i_reg] = 64'(s_reg) - 64'(ar_reg[i_reg]);
                    i_next = i_last ? 2'd0 : i_reg + 2'd1;
                end
            end
            ST_M00: if (alu_rsp.done) a00_next = a00_reg + r;
            ST_M01: if (alu_rsp.done) a01_next = a01_reg + r;
            ST_M11: if (alu_rsp.done) a11_next = a11_reg + r;
            ST_MG0: if (alu_rsp.done) g0_next = g0_reg - r;
            ST_MG1:
            begin
                if (alu_rsp.done)
                begin
                    g1_next = g1_reg - r;
                    i_next  = i_last ? 2'd0 : i_reg + 2'd1;
                end
            end
            ST_PIVOT:
            begin
                // a10 equals a01 before the swap
                a00_next = piv_a00;
                a10_next = piv_sw ? a00_reg : a01_reg;
                a01_next = piv_sw ? a11_reg : a01_reg;
                a11_next = piv_sw ? a01_reg : a11_reg;
                g0_next  = piv_sw ? g1_reg : g0_reg;
                g1_next  = piv_sw ? g0_reg : g1_reg;
                if (piv_a00 == '0)
                    status_next = STAT_SING;
            end
            ST_DIVM: if (alu_rsp.done) a10_next = r;
            ST_U11:  if (alu_rsp.done) a11_next = a11_reg - r;
            ST_G1:
            begin
                if (alu_rsp.done)
                begin
                    g1_next = g1_reg - r;
                    if (a11_reg == '0)
                        status_next = STAT_SING;
                end
            end
            ST_D1: if (alu_rsp.done) d1_next = r;
            ST_T:  if (alu_rsp.done) g0_next = g0_reg - r;
            ST_D0: if (alu_rsp.done) d0_next = r;
            ST_UPD:
            begin
                if (conv)
                    status_next = STAT_CONV;
                else
                begin
                    ex_next = clamp_pos(64'(ex_reg) + d0_reg);
                    ey_next = clamp_pos(64'(ey_reg) + d1_reg);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next.pos_x           = ex_reg;
                    out_next.pos_y           = ey_reg;
                    out_next.iterations_used = iter_reg;
                    out_next.status          = status_reg;
                    out_valid_next           = 1'b1;
                end
            end
            default: out_next = out_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        ar_reg     <= ar_next;
        jx_reg     <= jx_next;
        jy_reg     <= jy_next;
        res_reg    <= res_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        iter_reg   <= iter_next;
        status_reg <= status_next;
        i_reg      <= i_next;
        s_reg      <= s_next;
        a00_reg    <= a00_next;
        a01_reg    <= a01_next;
        a10_reg    <= a10_next;
        a11_reg    <= a11_next;
        g0_reg     <= g0_next;
        g1_reg     <= g1_next;
        d0_reg     <= d0_next;
        d1_reg     <= d1_next;
        out_reg    <= out_next;
    end

    assign fix_valid = out_valid_reg;
    assign fix       = out_reg;

    // a result from the shared unit only answers an issued operation
    ap_rsp_issued: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> issued_reg)
        else $error("shared unit result without an outstanding operation");

    // no iteration run only when the limit is zero, which reports the limit status
    ap_zero_iter: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid && fix.iterations_used == 8'd0 |-> fix.status == STAT_LIMIT)
        else $error("zero iterations with status other than limit");

    ap_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid |-> fix.iterations_used <= max_iter_reg)
        else $error("iteration count beyond the limit");

    ap_conv_iter: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid && fix.status == STAT_CONV |-> fix.iterations_used != 8'd0)
        else $error("converged without running an iteration");

endmodule
`default_nettype wire

@@ rtl/core/gnt_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gnt_alu
// Shared multi-cycle unit: saturating Q29 multiply (four 32x32 partial
// products), restoring Q29 divide (one quotient bit per cycle) and integer
// square root of a^2 + b^2 (one result bit per cycle).
// ----------------------------------------------------------------------------
module gnt_alu
    import gnt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  gnt_alu_req_t req,
    output gnt_alu_rsp_t rsp
);

    localparam logic [6:0] DIV_LAST = 7'(63 + JSH);
    localparam logic [6:0] MUL_LAST = 7'd5;
    localparam logic [6:0] SQ_FIRST = 7'd3;

    logic          busy_reg, busy_next;
    gnt_op_t       op_reg, op_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [63:0]   ua_reg, ua_next;
    logic [63:0]   ub_reg, ub_next;
    logic          neg_reg, neg_next;
    logic [127:0]  acc_reg, acc_next;
    logic [63:0]   pp_reg;
    logic [63:0]   rem_reg, rem_next;
    logic [63:0]   q_reg, q_next;
    logic [63:0]   sbit_reg, sbit_next;
    logic          done_reg, done_next;
    logic [63:0]   result_reg, result_next;

    logic [31:0]   mul_a, mul_b;
    logic [63:0]   prod;
    logic [127:0]  pp_shifted;
    logic [64:0]   rem_sh;
    logic          rem_ge;
    logic [63:0]   q_step;
    logic [63:0]   mul_q;
    logic [63:0]   sq_trial;
    logic          fin;
    logic [63:0]   fin_q;

    // partial product select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_MUL:
            begin
                mul_a = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
                mul_b = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
            end
            OP_SQRT:
            begin
                mul_a = cnt_reg[0] ? ub_reg[31:0] : ua_reg[31:0];
                mul_b = mul_a;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        pp_shifted = {64'd0, pp_reg};
        if (op_reg == OP_MUL)
        begin
            case (cnt_reg)
                7'd2, 7'd3: pp_shifted = {32'd0, pp_reg, 32'd0};
                7'd4:       pp_shifted = {pp_reg, 64'd0};
                default:    pp_shifted = {64'd0, pp_reg};
            endcase
        end
    end

    assign rem_sh   = {rem_reg, ua_reg[63]};
    assign rem_ge   = rem_sh >= {1'b0, ub_reg};
    assign q_step   = {q_reg[62:0], rem_ge};
    assign sq_trial = q_reg + sbit_reg;

    always_comb
    begin
        if (acc_reg[127:93] != '0)
            mul_q = LIMQ;
        else if (acc_reg[92:29] > LIMQ)
            mul_q = LIMQ;
        else
            mul_q = acc_reg[92:29];
    end

    always_comb
    begin
        busy_next   = busy_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        ua_next     = ua_reg;
        ub_next     = ub_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        sbit_next   = sbit_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        fin         = 1'b0;
        fin_q       = q_reg;

        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                op_next   = req.op;
                cnt_next  = '0;
                acc_next  = '0;
                rem_next  = '0;
                q_next    = '0;
                sbit_next = LIMQ;
                if (req.op == OP_SQRT)
                begin
                    ua_next  = 64'(req.opa);
                    ub_next  = 64'(req.opb);
                    neg_next = 1'b0;
                end
                else
                begin
                    ua_next  = mag64(req.opa);
                    ub_next  = mag64(req.opb);
                    neg_next = req.opa[63] ^ req.opb[63];
                end
            end
        end
        else
        begin
            cnt_next = cnt_reg + 7'd1;
            case (op_reg)
                OP_MUL:
                begin
                    if (cnt_reg != '0 && cnt_reg < MUL_LAST)
                        acc_next = acc_reg + pp_shifted;
                    if (cnt_reg == MUL_LAST)
                    begin
                        fin   = 1'b1;
                        fin_q = mul_q;
                    end
                end
                OP_SQRT:
                begin
                    if (cnt_reg == 7'd1 || cnt_reg == 7'd2)
                        acc_next = acc_reg + pp_shifted;
                    else if (cnt_reg >= SQ_FIRST)
                    begin
                        if (sbit_reg == '0)
                        begin
                            fin   = 1'b1;
                            fin_q = q_reg;
                        end
                        else
                        begin
                            if (acc_reg[63:0] >= sq_trial)
                            begin
                                acc_next = {64'd0, acc_reg[63:0] - sq_trial};
                                q_next   = (q_reg >> 1) + sbit_reg;
                            end
                            else
                                q_next = q_reg >> 1;
                            sbit_next = sbit_reg >> 2;
                        end
                    end
                end
                OP_DIV:
                begin
                    rem_next = rem_ge ? 64'(rem_sh - {1'b0, ub_reg}) : rem_sh[63:0];
                    ua_next  = ua_reg << 1;
                    q_next   = q_step;
                    if (q_step > LIMQ)
                    begin
                        fin   = 1'b1;
                        fin_q = LIMQ;
                    end
                    else if (cnt_reg == DIV_LAST)
                    begin
                        fin   = 1'b1;
                        fin_q = q_step;
                    end
                end
                default:
                begin
                    fin   = 1'b1;
                    fin_q = '0;
                end
            endcase
            if (fin)
            begin
                busy_next   = 1'b0;
                done_next   = 1'b1;
                result_next = neg_reg ? 64'(~fin_q + 64'd1) : fin_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        cnt_reg    <= cnt_next;
        ua_reg     <= ua_next;
        ub_reg     <= ub_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        pp_reg     <= prod;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        sbit_reg   <= sbit_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule
`default_nettype wire

@@ tb/tb_gauss_newton_trilateration.sv @@
// ----------------------------------------------------------------------------
// tb_gauss_newton_trilateration
// Self-checking bench for the Gauss-Newton trilateration core. A bit-exact
// fixed-point solver predicts each fix; anchor requests and fix results are
// throttled at random, and the APB registers move through several settings.
// ----------------------------------------------------------------------------
module tb_gauss_newton_trilateration;
    import gnt_pkg::*;

    typedef logic signed [63:0] s64;

    localparam logic [63:0] SAT_MAG = 64'h4000_0000_0000_0000;
    localparam int          QSH = 29;
    localparam s64          SNAP_RAW = ((s64'(1) << FRAC_BITS) + 5000) / 10000;
    localparam s64          ONE = s64'(1) << FRAC_BITS;
    localparam int          STALL_LIMIT = 1500000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        anchors_valid = 1'b0;
    logic        anchors_stall;
    gnt_in_t     anchors = '0;
    logic        fix_valid;
    logic        fix_stall = 1'b0;
    gnt_out_t    fix;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    gauss_newton_trilateration dut (.*);

    always #1 clk = ~clk;

    // register shadow
    logic signed [31:0] cfg_sx = -32'sd65536;
    logic signed [31:0] cfg_sy = -32'sd65536;
    logic [7:0]         cfg_iter = 8'd32;
    logic [15:0]        cfg_tol = 16'd1;

    gnt_in_t  pending[$];
    gnt_out_t fix_wait[$];
    int       errors = 0;
    int       sent = 0;
    int       checked = 0;
    int       stat_seen[3] = '{0, 0, 0};
    bit       calm = 1'b0;

    // ---------------- fixed-point solver ----------------
    function automatic logic [63:0] abs64(input s64 v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic s64 signed_sat(input logic [63:0] m, input bit neg);
        if (m > SAT_MAG) m = SAT_MAG;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] r, bt, v;
        v = x;
        r = '0;
        bt = 64'h4000_0000_0000_0000;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] range_of(input s64 dx, input s64 dy);
        logic [63:0] a, b;
        a = abs64(dx);
        b = abs64(dy);
        if (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
            a >>= 1;
            b >>= 1;
            return 64'd2 * root64(a * a + b * b);
        end
        return root64(a * a + b * b);
    endfunction

    function automatic s64 qmul(input s64 a, input s64 b);
        logic [127:0] p;
        logic [63:0]  q;
        p = 128'(abs64(a)) * 128'(abs64(b));
        q = (p[127:93] != 0) ? SAT_MAG : p[92:29];
        return signed_sat(q, a[63] != b[63]);
    endfunction

    function automatic s64 qdiv(input s64 n, input s64 d);
        logic [127:0] q;
        q = (128'(abs64(n)) << QSH) / 128'(abs64(d));
        return signed_sat((q > 128'(SAT_MAG)) ? SAT_MAG : q[63:0], n[63] != d[63]);
    endfunction

    function automatic s64 pin_pos(input s64 v);
        if (v > s64'(32'sh7fff_ffff)) v = s64'(32'sh7fff_ffff);
        if (v < -s64'(64'h8000_0000)) v = -s64'(64'h8000_0000);
        if (abs64(v) < SNAP_RAW) v = 0;
        return v;
    endfunction

    // one Gauss-Newton step at (ex, ey); 0 when the system is singular
    function automatic bit gn_iter(input s64 ax[3], input s64 ay[3], input s64 ar[3],
                                   input s64 ex, input s64 ey,
                                   output s64 d0, output s64 d1);
        s64          jx[3], jy[3], rs[3];
        s64          a00, a01, a10, a11, g0, g1, t, m, u11;
        logic [63:0] s;
        a00 = 0; a01 = 0; a11 = 0; g0 = 0; g1 = 0;
        d0 = 0; d1 = 0;
        for (int i = 0; i < 3; i++) begin
            s = range_of(ex - ax[i], ey - ay[i]);
            if (s == 0) return 1'b0;
            jx[i] = qdiv(ex - ax[i], $signed(s));
            jy[i] = qdiv(ey - ay[i], $signed(s));
            rs[i] = $signed(s) - ar[i];
        end
        for (int i = 0; i < 3; i++) begin
            a00 += qmul(jx[i], jx[i]);
            a01 += qmul(jx[i], jy[i]);
            a11 += qmul(jy[i], jy[i]);
            g0 -= qmul(jx[i], rs[i]);
            g1 -= qmul(jy[i], rs[i]);
        end
        a10 = a01;
        if (abs64(a10) > abs64(a00)) begin
            t = a00; a00 = a10; a10 = t;
            t = a01; a01 = a11; a11 = t;
            t = g0; g0 = g1; g1 = t;
        end
        if (a00 == 0) return 1'b0;
        m = qdiv(a10, a00);
        u11 = a11 - qmul(a01, m);
        g1 -= qmul(g0, m);
        if (u11 == 0) return 1'b0;
        d1 = qdiv(g1, u11);
        d0 = qdiv(g0 - qmul(a01, d1), a00);
        return 1'b1;
    endfunction

    function automatic gnt_out_t solve_fix(input gnt_in_t it);
        s64          ax[3], ay[3], ar[3];
        s64          ex, ey, d0, d1;
        logic [7:0]  used;
        gnt_status_t st;
        gnt_out_t    r;
        ax = '{it.anchor_a_x, it.anchor_b_x, it.anchor_c_x};
        ay = '{it.anchor_a_y, it.anchor_b_y, it.anchor_c_y};
        ar = '{s64'(it.anchor_a_range), s64'(it.anchor_b_range), s64'(it.anchor_c_range)};
        ex = cfg_sx;
        ey = cfg_sy;
        used = '0;
        st = STAT_LIMIT;
        for (int k = 1; k <= cfg_iter; k++) begin
            used = 8'(k);
            if (!gn_iter(ax, ay, ar, ex, ey, d0, d1)) begin
                st = STAT_SING;
                break;
            end
            if (abs64(d0) <= 64'(cfg_tol) && abs64(d1) <= 64'(cfg_tol)) begin
                st = STAT_CONV;
                break;
            end
            ex = pin_pos(ex + d0);
            ey = pin_pos(ey + d1);
        end
        r.pos_x = ex[31:0];
        r.pos_y = ey[31:0];
        r.iterations_used = used;
        r.status = st;
        return r;
    endfunction

    // ---------------- request driver ----------------
    always @(posedge clk) begin : drive_requests
        int gap;
        bit busy;
        busy = anchors_valid;
        if (anchors_valid && !anchors_stall) begin
            fix_wait.push_back(solve_fix(anchors));
            sent++;
            busy = 1'b0;
            gap = calm ? 0 : $urandom_range(0, 18);
        end
        if (!busy) begin
            if (gap > 0) begin
                gap--;
            end else if (pending.size() != 0) begin
                anchors <= pending.pop_front();
                busy = 1'b1;
            end
        end
        anchors_valid <= busy;
    end

    // ---------------- fix monitor ----------------
    always @(posedge clk) begin : check_fixes
        int       hold;
        gnt_out_t want;
        if (fix_valid && !fix_stall) begin
            if (fix_wait.size() == 0) begin
                $error("fix with no request outstanding: %h", fix);
                errors++;
            end else begin
                want = fix_wait.pop_front();
                checked++;
                if (fix.status < 3) stat_seen[fix.status]++;
                if (fix.pos_x !== want.pos_x) begin
                    $error("pos_x expected %0d got %0d", want.pos_x, fix.pos_x);
                    errors++;
                end
                if (fix.pos_y !== want.pos_y) begin
                    $error("pos_y expected %0d got %0d", want.pos_y, fix.pos_y);
                    errors++;
                end
                if (fix.iterations_used !== want.iterations_used) begin
                    $error("iterations_used expected %0d got %0d",
                           want.iterations_used, fix.iterations_used);
                    errors++;
                end
                if (fix.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, fix.status);
                    errors++;
                end
            end
            hold = calm ? 0 : $urandom_range(0, 18);
        end else if (hold > 0) begin
            hold--;
        end
        fix_stall <= (hold != 0);
    end

    // ---------------- watchdog ----------------
    always @(posedge clk) begin : watchdog
        int idle;
        if ((anchors_valid && !anchors_stall) || (fix_valid && !fix_stall) ||
            (psel && penable && pwrite && pready))
            idle = 0;
        else
            idle++;
        if (idle >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic drain();
        while (pending.size() != 0 || anchors_valid || fix_wait.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic reg_write(input gnt_reg_t r, input logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_cfg(input logic [31:0] sx, input logic [31:0] sy,
                           input logic [7:0] it, input logic [15:0] tol);
        drain();
        reg_write(REG_START_X, sx);
        reg_write(REG_START_Y, sy);
        reg_write(REG_MAX_ITER, 32'(it));
        reg_write(REG_STEP_TOL, 32'(tol));
        cfg_sx = sx;
        cfg_sy = sy;
        cfg_iter = it;
        cfg_tol = tol;
    endtask

    function automatic logic [30:0] measured(input s64 px, input s64 py,
                                             input s64 ax, input s64 ay, input int jit);
        s64 r;
        r = $signed(range_of(px - ax, py - ay));
        if (jit > 0) r += s64'($urandom_range(0, 2 * jit)) - jit;
        if (r < 0) r = 0;
        if (r > s64'(32'sh7fff_ffff)) r = s64'(32'sh7fff_ffff);
        return r[30:0];
    endfunction

    task automatic push_geo(input s64 px, input s64 py, input s64 a0x, input s64 a0y,
                            input s64 a1x, input s64 a1y, input s64 a2x, input s64 a2y,
                            input int jit);
        gnt_in_t it;
        it.anchor_a_x = a0x[31:0];
        it.anchor_a_y = a0y[31:0];
        it.anchor_a_range = measured(px, py, a0x, a0y, jit);
        it.anchor_b_x = a1x[31:0];
        it.anchor_b_y = a1y[31:0];
        it.anchor_b_range = measured(px, py, a1x, a1y, jit);
        it.anchor_c_x = a2x[31:0];
        it.anchor_c_y = a2y[31:0];
        it.anchor_c_range = measured(px, py, a2x, a2y, jit);
        pending.push_back(it);
    endtask

    task automatic push_noise();
        gnt_in_t it;
        it.anchor_a_x = $urandom;
        it.anchor_a_y = $urandom;
        it.anchor_a_range = $urandom;
        it.anchor_b_x = $urandom;
        it.anchor_b_y = $urandom;
        it.anchor_b_range = $urandom;
        it.anchor_c_x = $urandom;
        it.anchor_c_y = $urandom;
        it.anchor_c_range = $urandom;
        pending.push_back(it);
    endtask

    function automatic s64 spread(input int sh);
        return s64'($urandom_range(0, 32'(1) << (sh + 1))) - (s64'(1) << sh);
    endfunction

    task automatic push_random();
        int sh, kind;
        s64 px, py, sx, sy;
        sh = 16 + 4 * $urandom_range(0, 3);
        kind = $urandom_range(0, 99);
        px = spread(sh);
        py = spread(sh);
        sx = cfg_sx;
        sy = cfg_sy;
        if (kind < 75)
            push_geo(px, py, px + spread(sh), py + spread(sh), px + spread(sh),
                     py + spread(sh), px + spread(sh), py + spread(sh),
                     $urandom_range(0, 1) ? 0 : (1 << (sh - 12)));
        else if (kind < 85)
            push_noise();
        else if (kind < 92)     // one anchor sits on the start point
            push_geo(px, py, sx, sy, px + spread(sh), py + spread(sh),
                     px + spread(sh), py + spread(sh), 0);
        else if (kind < 97)     // anchors on the start point's horizontal line
            push_geo(px, py, sx + ONE, sy, sx - 3 * ONE, sy, sx + spread(sh), sy, 0);
        else
            push_geo(px, py, px + ONE, py, px + ONE, py, px + ONE, py, 0);
    endtask

    task automatic random_phase(input int n);
        repeat (n) push_random();
    endtask

    // ---------------- test sequence ----------------
    initial begin
        gnt_in_t it;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings
        calm = 1'b1;
        repeat (3) push_geo(0, 0, 5 * ONE, 0, 0, 6 * ONE, -4 * ONE, 3 * ONE, 0);
        calm = 1'b0;

        set_cfg(32'd0, 32'd0, 8'd6, 16'd64);
        push_geo(3 * ONE, 4 * ONE, -5 * ONE, -5 * ONE, 10 * ONE, 0, 0, 10 * ONE, 0);
        push_geo(ONE, ONE, 0, 0, 4 * ONE, 0, 0, 4 * ONE, 0);
        push_geo(ONE, ONE, ONE, 0, 2 * ONE, 0, 3 * ONE, 0, 0);
        push_geo(ONE, ONE, 0, ONE, 0, 2 * ONE, 0, -3 * ONE, 0);
        it = '1;
        it.anchor_a_y = 32'sh8000_0000;
        it.anchor_b_y = 32'sh8000_0000;
        it.anchor_c_y = 32'sh8000_0000;
        it.anchor_a_x = 32'sh7fff_ffff;
        it.anchor_b_x = 32'sh7fff_ffff;
        it.anchor_c_x = 32'sh7fff_ffff;
        pending.push_back(it);
        it = '0;
        it.anchor_a_x = 32'sh8000_0000;
        it.anchor_b_y = 32'sh7fff_ffff;
        it.anchor_c_x = -32'sd1;
        it.anchor_c_y = -32'sd1;
        pending.push_back(it);
        pending.push_back('0);
        push_geo(0, 0, -s64'(64'h8000_0000), 5 * ONE, s64'(32'sh7fff_ffff), -7 * ONE,
                 3 * ONE, -s64'(64'h8000_0000), 0);
        it = '0;
        it.anchor_a_x = ONE;
        it.anchor_b_y = ONE;
        it.anchor_c_x = -ONE;
        it.anchor_c_y = -ONE;
        it.anchor_a_range = '1;
        it.anchor_b_range = '1;
        it.anchor_c_range = '1;
        pending.push_back(it);
        push_geo(3, 2, 10 * ONE, 0, -10 * ONE, 10 * ONE, 0, -10 * ONE, 0);
        push_geo(ONE, ONE, 5 * ONE, 7 * ONE, 5 * ONE, 7 * ONE, 5 * ONE, 7 * ONE, 0);
        repeat (3) push_noise();

        // no iterations at all
        set_cfg(32'sh0012_3456, -32'sd7, 8'd0, 16'd0);
        repeat (4) push_random();

        // longest limit with the widest tolerance
        set_cfg(32'd0, 32'd0, 8'd255, 16'hffff);
        repeat (4) push_geo(spread(18), spread(18), 40 * ONE, 0, 0, 40 * ONE,
                            -40 * ONE, -40 * ONE, 0);

        // extreme start point
        set_cfg(32'h8000_0000, 32'h7fff_ffff, 8'd3, 16'd0);
        random_phase(20);

        for (int p = 0; p < 6; p++) begin
            set_cfg($urandom_range(0, 1) ? 32'(spread(24)) : 32'(spread(16)),
                    32'(spread(24)), 8'($urandom_range(1, 4)),
                    (p == 1) ? 16'hffff : (p == 2) ? 16'd0 : 16'($urandom));
            calm = (p % 3 == 0);
            random_phase(100);
        end

        drain();
        repeat (100) @(posedge clk);
        $display("Solved %0d anchor requests, %0d fixes checked", sent, checked);
        $display("Outcomes: %0d converged, %0d hit the limit, %0d singular",
                 stat_seen[0], stat_seen[1], stat_seen[2]);
        if (errors == 0 && fix_wait.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
